// File: rtl/sfdf_pkg.sv
package sfdf_pkg;

	localparam int DelayDepth = 524288;
	localparam int SampleBits = 24;

	localparam int CoefBits = 18;
	localparam int StateBits = 32;
	localparam int GainBits = 15;
	localparam int ModeBits = 2;
	localparam int CfgIdxBits = 3;
	localparam int CfgDataBits = 54;
	localparam int ProdBits = 64;
	localparam int AccBits = 64;

	localparam logic [CfgIdxBits-1:0] RegDelayLength = 3'd0;
	localparam logic [CfgIdxBits-1:0] RegFeedbackGain = 3'd1;
	localparam logic [CfgIdxBits-1:0] RegRoutingMode = 3'd2;
	localparam logic [CfgIdxBits-1:0] RegHighpass = 3'd3;
	localparam logic [CfgIdxBits-1:0] RegLowpass = 3'd4;

	localparam logic [ModeBits-1:0] ModeStereo = 2'd0;
	localparam logic [ModeBits-1:0] ModePingPong = 2'd1;
	localparam logic [ModeBits-1:0] ModeMono = 2'd2;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_FILT,
		ST_FB,
		ST_WRITE,
		ST_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic capture_in;
		logic rd_en;
		logic load;
		logic filt_step;
		logic fb_step;
		logic wr_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic filt_done;
		logic fb_done;
		logic clear_done;
	} stat_t;

	function automatic logic signed [63:0] sat64(input logic signed [63:0] v, input int bits);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		sat64 = (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

endpackage

// File: rtl/stereo_feedback_delay_filtered.sv
// Stereo delay with high-pass and low-pass filtered feedback, in stereo, ping-pong or
// mono routing. One stereo pair is processed at a time, in the order accept, read, load,
// twelve filter steps on one shared multiply-accumulate for two biquads per channel,
// two feedback steps, write, output; the next input is taken only after the output
// step. While an earlier result still waits in the output register, the new result
// holds in the output step and no input is taken. After reset the two delay memories
// are cleared one entry per cycle until every entry is zero, and no input is accepted
// meanwhile.
module stereo_feedback_delay_filtered #(
	parameter int DELAY_DEPTH = sfdf_pkg::DelayDepth,
	parameter int SAMPLE_BITS = sfdf_pkg::SampleBits
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [23:0]                in_left,
	input  logic signed [23:0]                in_right,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [23:0]                out_left,
	output logic signed [23:0]                out_right,
	input  logic                              cfg_we,
	input  logic [sfdf_pkg::CfgIdxBits-1:0]   cfg_index,
	input  logic [sfdf_pkg::CfgDataBits-1:0]  cfg_data
);

	logic [18:0] delay_length_q;
	logic [sfdf_pkg::GainBits-1:0] feedback_gain_q;
	logic [sfdf_pkg::ModeBits-1:0] routing_mode_q;
	logic [sfdf_pkg::CfgDataBits-1:0] hp_q, lp_q;
	sfdf_pkg::cmd_t cmd;
	sfdf_pkg::stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q <= 19'd24000;
			feedback_gain_q <= 15'd16384;
			routing_mode_q <= sfdf_pkg::ModeStereo;
			hp_q <= '0;
			lp_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfdf_pkg::RegDelayLength: delay_length_q <= cfg_data[18:0];
				sfdf_pkg::RegFeedbackGain: feedback_gain_q <= cfg_data[14:0];
				sfdf_pkg::RegRoutingMode: routing_mode_q <= cfg_data[1:0];
				sfdf_pkg::RegHighpass: hp_q <= cfg_data;
				sfdf_pkg::RegLowpass: lp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sfdf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	sfdf_datapath #(.DELAY_DEPTH(DELAY_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_left(in_left), .in_right(in_right),
		.delay_length(delay_length_q), .feedback_gain(feedback_gain_q),
		.routing_mode(routing_mode_q), .highpass_coeffs(hp_q), .lowpass_coeffs(lp_q),
		.out_left(out_left), .out_right(out_right)
	);

endmodule

// File: rtl/sfdf_ctrl.sv
module sfdf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  sfdf_pkg::stat_t  stat,
	output sfdf_pkg::cmd_t   cmd
);

	sfdf_pkg::state_t state_q, state_d;
	logic out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfdf_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			sfdf_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_done) state_d = sfdf_pkg::ST_IDLE;
			end
			sfdf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture_in = 1'b1;
					state_d = sfdf_pkg::ST_READ;
				end
			end
			sfdf_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d = sfdf_pkg::ST_LOAD;
			end
			sfdf_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = sfdf_pkg::ST_FILT;
			end
			sfdf_pkg::ST_FILT: begin
				cmd.filt_step = 1'b1;
				if (stat.filt_done) state_d = sfdf_pkg::ST_FB;
			end
			sfdf_pkg::ST_FB: begin
				cmd.fb_step = 1'b1;
				if (stat.fb_done) state_d = sfdf_pkg::ST_WRITE;
			end
			sfdf_pkg::ST_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d = sfdf_pkg::ST_OUT;
			end
			sfdf_pkg::ST_OUT: begin
				// wait until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = sfdf_pkg::ST_IDLE;
				end
			end
			default: state_d = sfdf_pkg::ST_IDLE;
		endcase
	end

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n)
		(state_q != sfdf_pkg::ST_IDLE) |-> !in_ready;
	endproperty
	assert property (p_no_accept_busy) else $error("input accepted while busy");

	property p_out_after_write;
		@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |=> (state_q == sfdf_pkg::ST_OUT);
	endproperty
	assert property (p_out_after_write) else $error("write not followed by output");

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && state_q != sfdf_pkg::ST_OUT) |=> out_valid_q;
	endproperty
	assert property (p_out_hold) else $error("result dropped");

endmodule

// File: rtl/sfdf_datapath.sv
module sfdf_datapath #(
	parameter int DELAY_DEPTH = sfdf_pkg::DelayDepth,
	parameter int SAMPLE_BITS = sfdf_pkg::SampleBits
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sfdf_pkg::cmd_t                         cmd,
	output sfdf_pkg::stat_t                        stat,
	input  logic signed [23:0]                     in_left,
	input  logic signed [23:0]                     in_right,
	input  logic [18:0]                            delay_length,
	input  logic [sfdf_pkg::GainBits-1:0]          feedback_gain,
	input  logic [sfdf_pkg::ModeBits-1:0]          routing_mode,
	input  logic [sfdf_pkg::CfgDataBits-1:0]       highpass_coeffs,
	input  logic [sfdf_pkg::CfgDataBits-1:0]       lowpass_coeffs,
	output logic signed [23:0]                     out_left,
	output logic signed [23:0]                     out_right
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int SB = SAMPLE_BITS;

	logic signed [SB-1:0] lmem [DELAY_DEPTH];
	logic signed [SB-1:0] rmem [DELAY_DEPTH];

	logic [AW-1:0] wp_q;
	logic [AW-1:0] clr_q;
	logic signed [SB-1:0] rd_l_q, rd_r_q;
	logic signed [SB-1:0] inl_q, inr_q;
	logic signed [SB-1:0] dl_q, dr_q;
	logic signed [SB-1:0] wl_q, wr_q;
	logic signed [SB-1:0] ol_q, or_q;

	// filter state: [chan][filter][0/1]
	logic signed [31:0] st_q [2][2][2];
	logic signed [SB-1:0] x_q;
	logic signed [SB-1:0] y_q;
	logic signed [SB-1:0] f_q [2];
	logic [1:0] sel_q;  // {chan, filter}
	logic [1:0] ph_q;   // 0 y, 1 s1, 2 s2
	logic [1:0] fbph_q;
	logic filt_last;

	// clamp of delay and read address, wrapping at the memory depth
	logic [31:0] dlen32;
	logic [AW-1:0] d_clamp;
	logic [AW:0] rsum;
	logic [AW-1:0] rp;
	logic [AW-1:0] wp_inc;
	always_comb begin
		dlen32 = 32'(delay_length);
		if (dlen32 == 32'd0) d_clamp = AW'(1);
		else if (dlen32 > 32'(DELAY_DEPTH - 1)) d_clamp = AW'(DELAY_DEPTH - 1);
		else d_clamp = AW'(dlen32);
		rsum = {1'b0, wp_q} + (AW+1)'(DELAY_DEPTH) - {1'b0, d_clamp};
		if (rsum >= (AW+1)'(DELAY_DEPTH)) rp = AW'(rsum - (AW+1)'(DELAY_DEPTH));
		else rp = AW'(rsum);
		wp_inc = (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	end

	function automatic logic signed [SB-1:0] sat_in(input logic signed [23:0] v);
		sat_in = SB'(sfdf_pkg::sat64(64'(v), SB));
	endfunction

	// shared multiply-accumulate for the filters
	logic [sfdf_pkg::CfgDataBits-1:0] pk;
	logic signed [17:0] b0, a1, a2;
	logic signed [31:0] s0, s1;
	logic signed [63:0] acc;
	logic signed [SB-1:0] y_new;
	logic signed [31:0] s_new;
	always_comb begin
		pk = sel_q[0] ? lowpass_coeffs : highpass_coeffs;
		b0 = pk[17:0];
		a1 = pk[35:18];
		a2 = pk[53:36];
		s0 = st_q[sel_q[1]][sel_q[0]][0];
		s1 = st_q[sel_q[1]][sel_q[0]][1];
		acc = '0;
		case (ph_q)
			2'd0: acc = 64'(b0) * 64'(x_q) + (64'(s0) <<< 8) + 64'sd32768;
			2'd1: acc = (sel_q[0] ? 64'sd2 : -64'sd2) * 64'(b0) * 64'(x_q)
				- 64'(a1) * 64'(y_q) + (64'(s1) <<< 8) + 64'sd128;
			default: acc = 64'(b0) * 64'(x_q) - 64'(a2) * 64'(y_q) + 64'sd128;
		endcase
		y_new = SB'(sfdf_pkg::sat64(acc >>> 16, SB));
		s_new = 32'(sfdf_pkg::sat64(acc >>> 8, 32));
	end
	assign filt_last = (sel_q == 2'b11) && (ph_q == 2'd2);

	// feedback
	logic signed [SB-1:0] fm;
	logic signed [SB-1:0] fsrc;
	logic signed [63:0] fprod;
	logic signed [SB-1:0] base;
	logic signed [63:0] wsum;
	always_comb begin
		fm = SB'((65'(f_q[0]) + 65'(f_q[1])) >>> 1);
		if (routing_mode == sfdf_pkg::ModeMono) begin
			fsrc = fm;
			base = SB'((65'(inl_q) + 65'(inr_q)) >>> 1);
		end else if (routing_mode == sfdf_pkg::ModePingPong) begin
			fsrc = fbph_q[0] ? f_q[0] : f_q[1];
			base = fbph_q[0] ? inr_q : inl_q;
		end else begin
			fsrc = fbph_q[0] ? f_q[1] : f_q[0];
			base = fbph_q[0] ? inr_q : inl_q;
		end
		fprod = 64'(fsrc) * $signed({1'b0, feedback_gain});
		wsum = 64'(base) + ((fprod + 64'sd16384) >>> 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			clr_q <= '0;
			sel_q <= '0;
			ph_q <= '0;
			fbph_q <= '0;
			for (int c = 0; c < 2; c++)
				for (int f = 0; f < 2; f++)
					for (int k = 0; k < 2; k++) st_q[c][f][k] <= '0;
		end else begin
			if (cmd.clear_wr) clr_q <= clr_q + AW'(1);
			if (cmd.wr_en) wp_q <= wp_inc;
			if (cmd.load) begin
				sel_q <= '0;
				ph_q <= '0;
				fbph_q <= '0;
			end
			if (cmd.filt_step) begin
				if (ph_q == 2'd0) begin
					ph_q <= 2'd1;
				end else if (ph_q == 2'd1) begin
					st_q[sel_q[1]][sel_q[0]][0] <= s_new;
					ph_q <= 2'd2;
				end else begin
					st_q[sel_q[1]][sel_q[0]][1] <= s_new;
					ph_q <= 2'd0;
					sel_q <= sel_q + 2'd1;
				end
			end
			if (cmd.fb_step) fbph_q <= fbph_q + 2'd1;
		end
	end

	// memories, cleared by a sweep after reset
	always_ff @(posedge clk) begin
		if (cmd.clear_wr) begin
			lmem[clr_q] <= '0;
			rmem[clr_q] <= '0;
		end else if (cmd.wr_en) begin
			lmem[wp_q] <= wl_q;
			rmem[wp_q] <= wr_q;
		end
		if (cmd.rd_en) begin
			rd_l_q <= lmem[rp];
			rd_r_q <= rmem[rp];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			inl_q <= sat_in(in_left);
			inr_q <= sat_in(in_right);
		end
		if (cmd.load) begin
			dl_q <= rd_l_q;
			dr_q <= rd_r_q;
			x_q <= rd_l_q;
		end
		if (cmd.filt_step) begin
			if (ph_q == 2'd0) y_q <= y_new;
			if (ph_q == 2'd2) begin
				if (sel_q[0]) begin
					f_q[sel_q[1]] <= y_q;
					x_q <= dr_q;
				end else begin
					x_q <= y_q;
				end
			end
		end
		// in mono mode both steps produce the same sum
		if (cmd.fb_step) begin
			if (fbph_q[0]) wr_q <= SB'(sfdf_pkg::sat64(wsum, SB));
			else wl_q <= SB'(sfdf_pkg::sat64(wsum, SB));
		end
		if (cmd.out_load) begin
			if (routing_mode == sfdf_pkg::ModeMono) begin
				ol_q <= fm;
				or_q <= fm;
			end else begin
				ol_q <= dl_q;
				or_q <= dr_q;
			end
		end
	end

	assign out_left = 24'(ol_q);
	assign out_right = 24'(or_q);

	assign stat.filt_done = filt_last;
	assign stat.fb_done = fbph_q[0];
	assign stat.clear_done = (clr_q == AW'(DELAY_DEPTH - 1));

	property p_wp_steps;
		@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |=> (wp_q == $past(wp_inc));
	endproperty
	assert property (p_wp_steps) else $error("write position did not advance");

	property p_wp_hold;
		@(posedge clk) disable iff (!arst_n)
		!cmd.wr_en |=> $stable(wp_q);
	endproperty
	assert property (p_wp_hold) else $error("write position moved");

	property p_filt_order;
		@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (sel_q == 2'b00 && ph_q == 2'd0);
	endproperty
	assert property (p_filt_order) else $error("filter sequence not restarted");

endmodule
